@@ rtl/ctsp_pkg.sv @@
// Shared constants for the cube to sphere point map pipeline.
// Depends on nothing; used by the lane module and the top level.
`default_nettype none
package ctsp_pkg;

	// Fixed point format of all coordinates.
	localparam int FRAC_BITS = 14;
	localparam int COORD_W   = 16;
	localparam int ONE       = 1 << FRAC_BITS;

	// Width of a truncated square: values reach ONE * 4 for 16-bit inputs.
	localparam int SQ_W   = 17;
	// Width of the product of two squares after truncation.
	localparam int PAB_W  = 19;
	// Division by three as a reciprocal multiply, exact below 2^RECIP3_SHIFT.
	localparam int RECIP3_SHIFT = 19;
	localparam int RECIP3_W     = 18;
	localparam logic [RECIP3_W-1:0] RECIP3 = RECIP3_W'(((1 << RECIP3_SHIFT) + 2) / 3);
	localparam int THIRD_W = 18;
	// Clamped radicand and the sign-aware sum that produces it.
	localparam int RAD_W   = 17;
	localparam int RSUM_W  = 20;
	// Square root: operand is rad << FRAC_BITS, one result bit per stage.
	localparam int SQRT_N_W  = 32;
	localparam int SQRT_STEPS = SQRT_N_W / 2;
	localparam int ROOT_W    = SQRT_STEPS;
	localparam int REM_W     = ROOT_W + 2;
	// Scaled product width after the final shift.
	localparam int PROD_W    = 2 * COORD_W - FRAC_BITS;

	// Stages: squares, half and cross product, third, radicand,
	// square root steps, final product, output.
	localparam int LATENCY = 4 + SQRT_STEPS + 2;

endpackage
`default_nettype wire

@@ rtl/cube_to_sphere_point_map_unit.sv @@
// Cube to sphere point map, pipelined from accepted input to valid output.
// Throughput one transaction per cycle; the whole pipeline advances together
// and holds while the output register is full and stalled.
// Reset clears only the stage valid bits; data registers are not reset.
// Depends on ctsp_pkg and ctsp_lane.
`default_nettype none
module cube_to_sphere_point_map_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [ctsp_pkg::COORD_W-1:0]    cube_x,
	input  wire logic [ctsp_pkg::COORD_W-1:0]    cube_y,
	input  wire logic [ctsp_pkg::COORD_W-1:0]    cube_z,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [ctsp_pkg::COORD_W-1:0]         sphere_x,
	output logic [ctsp_pkg::COORD_W-1:0]         sphere_y,
	output logic [ctsp_pkg::COORD_W-1:0]         sphere_z
);
	import ctsp_pkg::*;

	logic en;
	logic [LATENCY-1:0] valid_q;

	// Every stage moves when the output register is free or being taken.
	assign en        = !(valid_q[LATENCY-1] && out_stall);
	assign in_stall  = !en;
	assign out_valid = valid_q[LATENCY-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[LATENCY-2:0], in_valid};
		end
	end

	// First stage: magnitudes, signs and truncated squares.
	logic [COORD_W-1:0] mx, my, mz;
	logic [2*COORD_W-1:0] px, py, pz;
	logic [COORD_W-1:0] mx_s1, my_s1, mz_s1;
	logic nx_s1, ny_s1, nz_s1;
	logic [SQ_W-1:0] sx_s1, sy_s1, sz_s1;

	always_comb begin
		mx = cube_x[COORD_W-1] ? (~cube_x + COORD_W'(1)) : cube_x;
		my = cube_y[COORD_W-1] ? (~cube_y + COORD_W'(1)) : cube_y;
		mz = cube_z[COORD_W-1] ? (~cube_z + COORD_W'(1)) : cube_z;
		px = {{COORD_W{1'b0}}, mx} * {{COORD_W{1'b0}}, mx};
		py = {{COORD_W{1'b0}}, my} * {{COORD_W{1'b0}}, my};
		pz = {{COORD_W{1'b0}}, mz} * {{COORD_W{1'b0}}, mz};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1 <= mx;
			my_s1 <= my;
			mz_s1 <= mz;
			nx_s1 <= cube_x[COORD_W-1];
			ny_s1 <= cube_y[COORD_W-1];
			nz_s1 <= cube_z[COORD_W-1];
			sx_s1 <= px[FRAC_BITS +: SQ_W];
			sy_s1 <= py[FRAC_BITS +: SQ_W];
			sz_s1 <= pz[FRAC_BITS +: SQ_W];
		end
	end

	// One lane per output coordinate, each fed the other two squares.
	ctsp_lane u_lane_x (
		.clk(clk), .en(en), .sq_a(sy_s1), .sq_b(sz_s1),
		.mag(mx_s1), .neg(nx_s1), .result(sphere_x)
	);

	ctsp_lane u_lane_y (
		.clk(clk), .en(en), .sq_a(sz_s1), .sq_b(sx_s1),
		.mag(my_s1), .neg(ny_s1), .result(sphere_y)
	);

	ctsp_lane u_lane_z (
		.clk(clk), .en(en), .sq_a(sx_s1), .sq_b(sy_s1),
		.mag(mz_s1), .neg(nz_s1), .result(sphere_z)
	);

endmodule
`default_nettype wire

@@ rtl/ctsp_lane.sv @@
// One output coordinate lane: radicand, pipelined square root, scaling.
// Depends on ctsp_pkg; instantiated three times by the top level.
`default_nettype none
module ctsp_lane (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic [ctsp_pkg::SQ_W-1:0]      sq_a,
	input  wire logic [ctsp_pkg::SQ_W-1:0]      sq_b,
	input  wire logic [ctsp_pkg::COORD_W-1:0]   mag,
	input  wire logic                           neg,
	output logic [ctsp_pkg::COORD_W-1:0]        result
);
	import ctsp_pkg::*;

	logic [SQ_W-1:0]     half_s2;
	logic [PAB_W-1:0]    pab_s2;
	logic [THIRD_W-1:0]  third_s3;
	logic [SQ_W-1:0]     half_s3;
	logic [RAD_W-1:0]    rad_s4;
	logic [COORD_W-1:0]  mag_s2, mag_s3, mag_s4;
	logic                neg_s2, neg_s3, neg_s4;

	logic [SQ_W:0]              sum_ab;
	logic [2*SQ_W-1:0]          prod_ab;
	logic [PAB_W+RECIP3_W-1:0]  prod_r3;
	logic [RSUM_W-1:0]          rsum;

	// Radicand arithmetic ahead of the root.
	always_comb begin
		sum_ab  = {1'b0, sq_a} + {1'b0, sq_b};
		prod_ab = {{SQ_W{1'b0}}, sq_a} * {{SQ_W{1'b0}}, sq_b};
		prod_r3 = {{RECIP3_W{1'b0}}, pab_s2} * {{PAB_W{1'b0}}, RECIP3};
		rsum    = RSUM_W'(ONE) + RSUM_W'(third_s3) - RSUM_W'(half_s3);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			half_s2  <= sum_ab[SQ_W:1];
			pab_s2   <= prod_ab[FRAC_BITS +: PAB_W];
			mag_s2   <= mag;
			neg_s2   <= neg;
			third_s3 <= prod_r3[RECIP3_SHIFT +: THIRD_W];
			half_s3  <= half_s2;
			mag_s3   <= mag_s2;
			neg_s3   <= neg_s2;
			// A negative radicand is clamped to zero.
			rad_s4   <= rsum[RSUM_W-1] ? '0 : rsum[RAD_W-1:0];
			mag_s4   <= mag_s3;
			neg_s4   <= neg_s3;
		end
	end

	// Restoring square root, one result bit per stage.
	logic [SQRT_N_W-1:0] n_q    [0:SQRT_STEPS-1];
	logic [REM_W-1:0]    rem_q  [0:SQRT_STEPS-1];
	logic [ROOT_W-1:0]   root_q [0:SQRT_STEPS-1];
	logic [COORD_W-1:0]  mag_q  [0:SQRT_STEPS-1];
	logic                neg_q  [0:SQRT_STEPS-1];

	logic [SQRT_N_W-1:0] n_nx    [0:SQRT_STEPS-1];
	logic [REM_W-1:0]    rem_nx  [0:SQRT_STEPS-1];
	logic [ROOT_W-1:0]   root_nx [0:SQRT_STEPS-1];

	always_comb begin
		logic [SQRT_N_W-1:0] src_n;
		logic [REM_W-1:0]    src_rem;
		logic [ROOT_W-1:0]   src_root;
		logic [REM_W+1:0]    shifted;
		logic [REM_W+1:0]    trial;
		for (int k = 0; k < SQRT_STEPS; k++) begin
			if (k == 0) begin
				src_n    = SQRT_N_W'({rad_s4, {FRAC_BITS{1'b0}}});
				src_rem  = '0;
				src_root = '0;
			end else begin
				src_n    = n_q[k-1];
				src_rem  = rem_q[k-1];
				src_root = root_q[k-1];
			end
			shifted = {src_rem, src_n[SQRT_N_W-1 -: 2]};
			trial   = (REM_W+2)'({src_root, 2'b01});
			n_nx[k] = {src_n[SQRT_N_W-3:0], 2'b00};
			if (shifted >= trial) begin
				rem_nx[k]  = REM_W'(shifted - trial);
				root_nx[k] = {src_root[ROOT_W-2:0], 1'b1};
			end else begin
				rem_nx[k]  = shifted[REM_W-1:0];
				root_nx[k] = {src_root[ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_q[0] <= mag_s4;
			neg_q[0] <= neg_s4;
			for (int k = 0; k < SQRT_STEPS; k++) begin
				n_q[k]    <= n_nx[k];
				rem_q[k]  <= rem_nx[k];
				root_q[k] <= root_nx[k];
			end
			for (int k = 1; k < SQRT_STEPS; k++) begin
				mag_q[k]  <= mag_q[k-1];
				neg_q[k]  <= neg_q[k-1];
			end
		end
	end

	// Scale the coordinate magnitude by the root, then clamp and restore sign.
	logic [2*COORD_W-1:0] prod_full;
	logic [PROD_W-1:0]    prod_s21;
	logic                 neg_s21;
	logic [COORD_W-1:0]   mag_clip;

	always_comb begin
		prod_full = {{(2*COORD_W-COORD_W){1'b0}}, mag_q[SQRT_STEPS-1]}
			* {{(2*COORD_W-ROOT_W){1'b0}}, root_q[SQRT_STEPS-1]};
		mag_clip  = (prod_s21 > PROD_W'(ONE)) ? COORD_W'(ONE) : prod_s21[COORD_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s21 <= prod_full[FRAC_BITS +: PROD_W];
			neg_s21  <= neg_q[SQRT_STEPS-1];
			result   <= neg_s21 ? (~mag_clip + COORD_W'(1)) : mag_clip;
		end
	end

endmodule
`default_nettype wire

@@ rtl/ctsp_checker.sv @@
// Port-level checks for the cube to sphere point map unit, bound to the top.
// Depends on ctsp_pkg for the coordinate format.
`default_nettype none
module ctsp_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_stall,
	input wire logic                         out_valid,
	input wire logic                         out_stall,
	input wire logic [ctsp_pkg::COORD_W-1:0] sphere_x,
	input wire logic [ctsp_pkg::COORD_W-1:0] sphere_y,
	input wire logic [ctsp_pkg::COORD_W-1:0] sphere_z
);
	import ctsp_pkg::*;

	// The input side only backs up when a finished result is held.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held result");

	// A stalled result keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(sphere_x)
			&& $stable(sphere_y) && $stable(sphere_z)))
		else $error("stalled result changed");

	// A result only leaves after its transaction completes.
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("result dropped while stalled");

	// Every delivered coordinate lies on or inside the unit range.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(sphere_x) <= ONE && $signed(sphere_x) >= -ONE
			&& $signed(sphere_y) <= ONE && $signed(sphere_y) >= -ONE
			&& $signed(sphere_z) <= ONE && $signed(sphere_z) >= -ONE))
		else $error("coordinate beyond unit range");

endmodule

bind cube_to_sphere_point_map_unit ctsp_checker u_ctsp_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall),
	.sphere_x(sphere_x), .sphere_y(sphere_y), .sphere_z(sphere_z)
);
`default_nettype wire

@@ sim/cube_to_sphere_point_map_unit_tb.sv @@
// Self-checking testbench for the cube to sphere point map unit.
// Predicts each sphere point in fixed point and compares it with the block's output.
// Depends on ctsp_pkg and the cube_to_sphere_point_map_unit RTL.
`default_nettype none
module cube_to_sphere_point_map_unit_tb;
	import ctsp_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = LATENCY + 10;
	localparam int N_RANDOM       = 930;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [COORD_W-1:0] cube_x = '0, cube_y = '0, cube_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [COORD_W-1:0] sphere_x, sphere_y, sphere_z;

	point_t cube_points[$];
	point_t sphere_expected[$];
	int idle_phase = 0;
	int n_mismatch = 0;
	int n_checked = 0;
	int quiet_cycles = 0;
	bit stimulus_done = 1'b0;

	cube_to_sphere_point_map_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cube_x(cube_x), .cube_y(cube_y), .cube_z(cube_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.sphere_x(sphere_x), .sphere_y(sphere_y), .sphere_z(sphere_z)
	);

	// Clock with a 12 unit period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Appends a point to the stimulus queue.
	function automatic void add_point(point_t p);
		cube_points.insert(cube_points.size(), p);
	endfunction

	// Truncated square of a coordinate.
	function automatic longint fx_square(longint v);
		longint m;
		m = (v < 0) ? -v : v;
		return (m * m) >>> FRAC_BITS;
	endfunction

	function automatic longint int_sqrt(longint n);
		longint r;
		r = 0;
		for (longint b = 64'sd1 <<< 20; b > 0; b = b >>> 1)
			if ((r + b) * (r + b) <= n)
				r = r + b;
		return r;
	endfunction

	// One output coordinate from its own input and the squares of the other two.
	function automatic logic [COORD_W-1:0] sphere_coord(longint v, longint sa, longint sb);
		longint half, third, rad, root, mag, prod, res;
		half  = (sa + sb) >>> 1;
		third = ((sa * sb) >>> FRAC_BITS) / 3;
		rad   = ONE - half + third;
		if (rad < 0)
			rad = 0;
		root = int_sqrt(rad <<< FRAC_BITS);
		mag  = (v < 0) ? -v : v;
		prod = (mag * root) >>> FRAC_BITS;
		if (prod > ONE)
			prod = ONE;
		res = (v < 0) ? -prod : prod;
		if (res > 32767)
			res = 32767;
		if (res < -32768)
			res = -32768;
		return res[COORD_W-1:0];
	endfunction

	function automatic point_t map_to_sphere(point_t p);
		longint x, y, z, xs, ys, zs;
		point_t s;
		x = longint'($signed(p.x));
		y = longint'($signed(p.y));
		z = longint'($signed(p.z));
		xs = fx_square(x);
		ys = fx_square(y);
		zs = fx_square(z);
		s.x = sphere_coord(x, ys, zs);
		s.y = sphere_coord(y, zs, xs);
		s.z = sphere_coord(z, xs, ys);
		return s;
	endfunction

	// Random coordinate: mostly in range, sometimes any 16-bit pattern.
	function automatic logic [COORD_W-1:0] rand_coord();
		if ($urandom_range(9) == 0)
			return COORD_W'($urandom);
		return COORD_W'($urandom_range(2 * ONE) - ONE);
	endfunction

	// A point on a random face of the cube, or a stray point.
	function automatic point_t rand_point();
		point_t p;
		logic [COORD_W-1:0] face;
		p.x = rand_coord();
		p.y = rand_coord();
		p.z = rand_coord();
		if ($urandom_range(4) != 0) begin
			face = $urandom_range(1) ? COORD_W'(ONE) : COORD_W'(-ONE);
			case ($urandom_range(2))
				0: p.x = face;
				1: p.y = face;
				default: p.z = face;
			endcase
		end
		return p;
	endfunction

	function automatic bit idle_now(bit sender);
		int pct;
		case (idle_phase)
			0: pct = sender ? 22 : 49;
			1: pct = sender ? 49 : 22;
			default: pct = 0;
		endcase
		return $urandom_range(99) < pct;
	endfunction

	// Driver: presents queued points, with random gaps, and stalls the output at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || !in_stall) begin
				if (cube_points.size() > 0 && !idle_now(1'b1)) begin
					point_t p;
					p = cube_points.pop_front();
					sphere_expected.insert(sphere_expected.size(), map_to_sphere(p));
					in_valid <= 1'b1;
					cube_x <= p.x;
					cube_y <= p.y;
					cube_z <= p.z;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= idle_now(1'b0);
		end
	end

	// Monitor: checks each accepted result against the oldest prediction, with a watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (out_valid && !out_stall) begin
				n_checked <= n_checked + 1;
				if (sphere_expected.size() == 0) begin
					n_mismatch <= n_mismatch + 1;
					if (n_mismatch < 10)
						$display("unexpected transaction %h %h %h",
							sphere_x, sphere_y, sphere_z);
				end else begin
					point_t e;
					e = sphere_expected.pop_front();
					if (e.x !== sphere_x || e.y !== sphere_y || e.z !== sphere_z) begin
						n_mismatch <= n_mismatch + 1;
						if (n_mismatch < 10)
							$display("mismatch: expected %h %h %h, got %h %h %h",
								e.x, e.y, e.z, sphere_x, sphere_y, sphere_z);
					end
				end
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired with %0d results pending",
					sphere_expected.size());
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		point_t p;
		logic [COORD_W-1:0] ext[6];
		ext = '{COORD_W'(ONE), COORD_W'(-ONE), 16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
		// Directed: corners, face centers, edges, extreme patterns, negative radicand.
		for (int i = 0; i < 6; i++) begin
			p.x = ext[i];
			p.y = ext[(i + 1) % 6];
			p.z = ext[(i + 3) % 6];
			add_point(p);
		end
		add_point('{COORD_W'(ONE), COORD_W'(ONE), COORD_W'(ONE)});
		add_point('{COORD_W'(-ONE), COORD_W'(-ONE), COORD_W'(-ONE)});
		add_point('{COORD_W'(ONE), 16'h0000, 16'h0000});
		add_point('{16'h0000, COORD_W'(-ONE), 16'h0000});
		add_point('{16'h0000, 16'h0000, COORD_W'(ONE)});
		add_point('{COORD_W'(ONE), COORD_W'(ONE), 16'h0000});
		add_point('{COORD_W'(ONE), 16'h2000, 16'hE000});
		add_point('{16'h7FFF, 16'h7FFF, 16'h7FFF});
		add_point('{16'h8000, 16'h8000, 16'h8000});
		add_point('{16'h6000, 16'h6000, 16'h1000});
		add_point('{16'h5555, 16'hAAAA, 16'h0001});
		add_point('{16'h0001, 16'hFFFF, COORD_W'(ONE)});

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Random points in three idling phases.
		for (int ph = 0; ph < 3; ph++) begin
			for (int i = 0; i < N_RANDOM / 3; i++)
				add_point(rand_point());
			while (cube_points.size() > 0)
				@(posedge clk);
			@(posedge clk);
			idle_phase = ph + 1;
		end
		while (sphere_expected.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("checked %0d sphere points from cube faces, corners and stray inputs",
			n_checked);
		$display("idling covered sender-heavy, receiver-heavy and back-to-back phases");
		if (n_mismatch == 0 && sphere_expected.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire
